FILE: rtl/park_miller_random_generator_unit_macros.svh
// Assertion macros for the generator RTL; used by pmrg_ctrl.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef PARK_MILLER_RANDOM_GENERATOR_UNIT_MACROS_SVH
`define PARK_MILLER_RANDOM_GENERATOR_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define PMRG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define PMRG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/pmrg_pkg.sv
// Shared types and constants for the Lehmer generator.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package pmrg_pkg;

  localparam int WORD_W    = 32;
  localparam int HALF_W    = 16;
  localparam int MULT_W    = 15;
  localparam int PROD_W    = MULT_W + HALF_W;
  localparam int DIV_CNT_W = 5;

  localparam logic [MULT_W-1:0]    MULT_A      = 15'd16807;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST    = 5'd31;
  localparam logic [WORD_W-1:0]    STATE_RESET = 32'd1;

  // Operation codes carried in the input tuser
  localparam logic OP_DRAW   = 1'b0;
  localparam logic OP_RESEED = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED,
    ST_MUL,
    ST_FOLD,
    ST_WRAP,
    ST_DIV,
    ST_EMIT
  } pmrg_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic cap;
    logic seed_load;
    logic mul;
    logic fold;
    logic wrap;
    logic div_step;
    logic emit;
  } pmrg_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic span_zero;
    logic div_last;
  } pmrg_sts_t;

endpackage

FILE: rtl/pmrg_ctrl.sv
// Sequencing state machine of the generator: handshakes and step commands.
// Depends on pmrg_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "park_miller_random_generator_unit_macros.svh"

module pmrg_ctrl
  import pmrg_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  logic      in_op,
  output logic      out_tvalid,
  input  logic      out_tready,
  input  pmrg_sts_t sts,
  output pmrg_cmd_t cmd
);

  pmrg_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;

  // State and output-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and step commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_tready     = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.cap   = 1'b1;
          state_nxt = (in_op == OP_RESEED) ? ST_SEED : ST_MUL;
        end
      end
      ST_SEED: begin
        cmd.seed_load = 1'b1;
        state_nxt     = ST_EMIT;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_FOLD;
      end
      ST_FOLD: begin
        cmd.fold  = 1'b1;
        state_nxt = ST_WRAP;
      end
      ST_WRAP: begin
        cmd.wrap  = 1'b1;
        state_nxt = sts.span_zero ? ST_EMIT : ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // hold the finished item until the output register is free
        if (out_free) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `PMRG_ASSERT_NOW(a_emit_free, cmd.emit, out_free, "emit while output register is held")
  `PMRG_ASSERT_NEXT(a_div_end, (state_r == ST_DIV) && sts.div_last, state_r == ST_EMIT,
                    "divider end did not lead to emit")
  `PMRG_ASSERT_NEXT(a_emit_valid, cmd.emit, out_tvalid, "emitted item not presented")
  `PMRG_ASSERT_NEXT(a_draw_start, in_tvalid && in_tready && (in_op == OP_DRAW),
                    state_r == ST_MUL, "draw item did not start the multiply")

endmodule

FILE: rtl/pmrg_dp.sv
// Datapath of the generator: state register, split multiply, fold,
// radix-2 remainder unit and the output register. Depends on pmrg_pkg.
`timescale 1ns / 1ps

module pmrg_dp
  import pmrg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  pmrg_cmd_t         cmd,
  output pmrg_sts_t         sts,
  input  logic              in_op,
  input  logic [WORD_W-1:0] in_seed,
  input  logic [WORD_W-1:0] in_low,
  input  logic [WORD_W-1:0] in_high,
  output logic [WORD_W-1:0] out_raw,
  output logic [WORD_W-1:0] out_ranged,
  output logic              out_empty
);

  logic                 op_r;
  logic [WORD_W-1:0]    seed_r, low_r, span_r;
  logic [WORD_W-1:0]    gen_r, gen_nxt;
  logic [PROD_W-1:0]    plo_r, phi_r;
  logic [WORD_W-1:0]    sum_r, sum_nxt;
  logic [WORD_W-1:0]    rem_r, dvd_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [WORD_W-1:0]    raw_r, ranged_r;
  logic                 empty_r;
  logic [WORD_W-1:0]    seed_inc, fold_val;
  logic [WORD_W:0]      shifted, trial;
  logic [WORD_W-1:0]    rem_nxt, ranged_nxt;

  assign sts.span_zero = (span_r == '0);
  assign sts.div_last  = (cnt_r == DIV_LAST);

  // Reseed value: seed plus one; a zero result is replaced by 1 when loaded
  assign seed_inc = seed_r + WORD_W'(1);

  // Sum of the low product, the shifted low part of the high product and its top part
  assign sum_nxt = {{(WORD_W-PROD_W){1'b0}}, plo_r}
                 + {{(WORD_W-PROD_W){1'b0}}, phi_r[MULT_W-1:0], {HALF_W{1'b0}}}
                 + {{(WORD_W-(PROD_W-MULT_W)){1'b0}}, phi_r[PROD_W-1:MULT_W]};

  // Fold bit 31 back into the low 31 bits
  assign fold_val = {1'b0, sum_r[WORD_W-2:0]} + {{(WORD_W-1){1'b0}}, sum_r[WORD_W-1]};

  always_comb begin
    gen_nxt = gen_r;
    if (cmd.seed_load) begin
      gen_nxt = (seed_inc == '0) ? STATE_RESET : seed_inc;
    end else if (cmd.wrap) begin
      gen_nxt = fold_val;
    end
  end

  // One restoring step: shift in the next dividend bit, subtract when it fits
  assign shifted = {rem_r, dvd_r[WORD_W-1]};
  assign trial   = shifted - {1'b0, span_r};
  assign rem_nxt = trial[WORD_W] ? shifted[WORD_W-1:0] : trial[WORD_W-1:0];

  always_comb begin
    if (op_r == OP_RESEED) begin
      ranged_nxt = '0;
    end else if (sts.span_zero) begin
      ranged_nxt = low_r;
    end else begin
      ranged_nxt = rem_r + low_r;
    end
  end

  // Generator state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r <= STATE_RESET;
    end else begin
      gen_r <= gen_nxt;
    end
  end

  // Operand capture, products, fold and remainder
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      op_r   <= in_op;
      seed_r <= in_seed;
      low_r  <= in_low;
      span_r <= in_high - in_low;
    end
    if (cmd.mul) begin
      plo_r <= PROD_W'(MULT_A) * PROD_W'(gen_r[HALF_W-1:0]);
      phi_r <= PROD_W'(MULT_A) * PROD_W'(gen_r[WORD_W-1:HALF_W]);
    end
    if (cmd.fold) begin
      sum_r <= sum_nxt;
    end
    if (cmd.wrap) begin
      dvd_r <= fold_val;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[WORD_W-2:0], 1'b0};
      rem_r <= rem_nxt;
      cnt_r <= cnt_r + DIV_CNT_W'(1);
    end
    if (cmd.emit) begin
      raw_r    <= gen_r;
      ranged_r <= ranged_nxt;
      empty_r  <= (op_r == OP_DRAW) && sts.span_zero;
    end
  end

  assign out_raw    = raw_r;
  assign out_ranged = ranged_r;
  assign out_empty  = empty_r;

endmodule

FILE: rtl/park_miller_random_generator_unit.sv
// Minimal-standard Lehmer generator with ranged draws.
// Channels: in_* takes one item per draw or reseed; in_tuser[0] is the
//   operation (0 draw, 1 reseed), in_tdata holds seed, low and high bounds.
//   out_* returns one item per input: raw state, ranged value and the
//   empty-span flag in out_tuser.
// Sequence: a draw runs the multiply, sum and fold, then the one-bit-per-cycle
//   remainder unit before out_tvalid; a reseed or an empty span skips the
//   remainder unit.
// Throughput: one item at a time; no new item is accepted until the
//   current one has been written to the output register.
// Reset: synchronous, active low; the generator state becomes 1 and no
//   item is pending.
// Stall: a finished item sits in the output register while the next item
//   is accepted and worked on; that next item waits before its output
//   write until the register has been taken.
// Depends on pmrg_pkg, pmrg_ctrl and pmrg_dp.
`timescale 1ns / 1ps

module park_miller_random_generator_unit
  import pmrg_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // seed_in[31:0], range_low[63:32], range_high[95:64]
  input  logic [0:0]  in_tuser,   // operation[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // raw_value[31:0], ranged_value[63:32]
  output logic [0:0]  out_tuser   // empty_range[0]
);

  pmrg_cmd_t         cmd;
  pmrg_sts_t         sts;
  logic [WORD_W-1:0] raw_value, ranged_value;
  logic              empty_range;

  // Sequencer
  pmrg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_op      (in_tuser[0]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Arithmetic and output register
  pmrg_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_op      (in_tuser[0]),
    .in_seed    (in_tdata[31:0]),
    .in_low     (in_tdata[63:32]),
    .in_high    (in_tdata[95:64]),
    .out_raw    (raw_value),
    .out_ranged (ranged_value),
    .out_empty  (empty_range)
  );

  assign out_tdata = {ranged_value, raw_value};
  assign out_tuser = empty_range;

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for the Lehmer generator unit: directed corner items, then random
// draws and reseeds under random back-pressure. Depends on pmrg_pkg and the unit RTL.
`timescale 1ns / 1ps

module tb_top;
  import pmrg_pkg::*;

  localparam int RANDOM_ITEMS  = 1280;
  localparam int LONG_HOLD_AT  = 300;   // results seen before the long receiver hold
  localparam int LONG_HOLD_LEN = 400;
  localparam int TAIL_CYCLES   = 120;

  typedef struct {
    logic        op;
    logic [31:0] seed;
    logic [31:0] lo_b;     // signed bound, kept as raw bits
    logic [31:0] hi_b;     // signed bound, kept as raw bits
    int          gap;      // idle cycles after this item is taken
    bit          wait_drain;
  } gen_req_t;

  typedef struct {
    logic [31:0] raw;
    logic [31:0] ranged;
    logic        empty;
  } gen_out_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [95:0] in_tdata;
  logic [0:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;
  logic [0:0]  out_tuser;

  gen_req_t    request_queue[$];
  gen_out_t    awaited_outputs[$];
  logic [31:0] model_state;
  int          errors       = 0;
  int          results_seen = 0;
  int          items_queued = 0;
  bit          in_taken     = 1'b0;

  park_miller_random_generator_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // One Lehmer step: 16807 times each 16-bit half, recombine, fold bit 31 back once
  function automatic logic [31:0] lehmer_advance(input logic [31:0] s);
    logic [31:0] lo_p;
    logic [31:0] hi_p;
    lo_p = 32'd16807 * {16'd0, s[15:0]};
    hi_p = 32'd16807 * {16'd0, s[31:16]};
    lo_p = lo_p + {1'b0, hi_p[14:0], 16'd0};
    hi_p = hi_p >> 15;
    lo_p = lo_p + hi_p;
    return {1'b0, lo_p[30:0]} + {31'd0, lo_p[31]};
  endfunction

  // Work out the result of one item and advance the generator state
  function automatic gen_out_t lehmer_outcome(input gen_req_t r);
    gen_out_t    o;
    logic [31:0] span;
    o.ranged = '0;
    o.empty  = 1'b0;
    if (r.op == OP_RESEED) begin
      model_state = (r.seed + 32'd1 == 32'd0) ? 32'd1 : r.seed + 32'd1;
    end else begin
      span        = r.hi_b - r.lo_b;
      model_state = lehmer_advance(model_state);
      if (span == 32'd0) begin
        o.empty  = 1'b1;
        o.ranged = r.lo_b;
      end else begin
        o.ranged = (model_state % span) + r.lo_b;
      end
    end
    o.raw = model_state;
    return o;
  endfunction

  // Gap after an item: mostly none or short, a few long, quiet stretches with none
  function automatic int pick_gap(input int idx);
    int r;
    r = $urandom_range(0, 99);
    if ((idx / 100) % 5 == 4) return 0;
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 5);
    if (r < 97) return $urandom_range(6, 20);
    return $urandom_range(30, 60);
  endfunction

  task automatic add_item(input logic op, input logic [31:0] seed,
                          input logic [31:0] lo_b, input logic [31:0] hi_b);
    gen_req_t r;
    r.op         = op;
    r.seed       = seed;
    r.lo_b       = lo_b;
    r.hi_b       = hi_b;
    r.gap        = (items_queued < 25) ? items_queued % 3 : pick_gap(items_queued);
    r.wait_drain = (items_queued == 25 || items_queued == 600 || items_queued == 1000);
    request_queue.push_back(r);
    items_queued++;
  endtask

  // Random item: mostly draws over varied spans, some reseeds including wrap cases
  task automatic add_random_item();
    logic [31:0] lo_b;
    logic [31:0] hi_b;
    logic [31:0] seed;
    int          kind;
    lo_b = $urandom;
    hi_b = $urandom;
    seed = $urandom;
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      case ($urandom_range(0, 9))
        0: seed = 32'h0000_0000;
        1: seed = 32'hFFFF_FFFF;
        2: seed = 32'hFFFF_FFFE;
        3: seed = 32'h7FFF_FFFE;
        4: seed = 32'h7FFF_FFFF;
        default: ;
      endcase
      add_item(OP_RESEED, seed, lo_b, hi_b);
    end else begin
      if (kind < 40) begin
        hi_b = lo_b + $urandom_range(1, 100);
      end else if (kind < 52) begin
        hi_b = lo_b;
      end else if (kind < 62) begin
        hi_b = lo_b - $urandom_range(1, 1000);
      end else if (kind < 77) begin
        hi_b = lo_b + (32'd1 << $urandom_range(0, 31)) + $urandom_range(0, 2) - 1;
      end
      add_item(OP_DRAW, seed, lo_b, hi_b);
    end
  endtask

  // Driver: offer the next item at the falling edge, hold it until taken
  int       gap_left = 0;
  int       cur_gap  = 0;
  always @(negedge clk) begin : drive_p
    gen_req_t itm;
    logic     offer;
    if (rst_n && !(in_tvalid && !in_taken)) begin
      if (in_tvalid) gap_left = cur_gap;
      offer = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (request_queue.size() != 0 &&
                   (!request_queue[0].wait_drain || awaited_outputs.size() == 0)) begin
        itm      = request_queue.pop_front();
        in_tdata <= {itm.hi_b, itm.lo_b, itm.seed};
        in_tuser <= itm.op;
        cur_gap  = itm.gap;
        offer    = 1'b1;
      end
      in_tvalid <= offer;
    end
  end

  // Receiver: random stalls, quiet stretches, and one long hold to back the block up
  int  stall_left = 0;
  int  hold_left  = 0;
  bit  long_done  = 1'b0;
  always @(negedge clk) begin : sink_p
    int r;
    if (rst_n) begin
      if (!long_done && results_seen >= LONG_HOLD_AT) begin
        long_done = 1'b1;
        hold_left = LONG_HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if ((results_seen / 200) % 4 != 3 && $urandom_range(0, 7) == 0) begin
          stall_left = (r < 70) ? $urandom_range(0, 2) :
                       (r < 95) ? $urandom_range(3, 9) : $urandom_range(20, 60);
          out_tready <= 1'b0;
        end else begin
          out_tready <= 1'b1;
        end
      end
    end
  end

  // Monitor: predict on input acceptance, compare on output acceptance
  always @(posedge clk) begin : watch_p
    gen_req_t r;
    gen_out_t want;
    if (!rst_n) begin
      in_taken    = 1'b0;
      model_state = STATE_RESET;
    end else begin
      in_taken = in_tvalid && in_tready;
      if (in_taken) begin
        r.op   = in_tuser[0];
        r.seed = in_tdata[31:0];
        r.lo_b = in_tdata[63:32];
        r.hi_b = in_tdata[95:64];
        awaited_outputs.push_back(lehmer_outcome(r));
      end
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (awaited_outputs.size() == 0) begin
          $display("%0t: unexpected item: raw %h ranged %h empty %b", $time,
                   out_tdata[31:0], out_tdata[63:32], out_tuser[0]);
          errors++;
        end else begin
          want = awaited_outputs.pop_front();
          if (out_tdata[31:0] !== want.raw) begin
            $display("%0t: raw_value expected %h, actual %h", $time, want.raw,
                     out_tdata[31:0]);
            errors++;
          end
          if (out_tdata[63:32] !== want.ranged) begin
            $display("%0t: ranged_value expected %h, actual %h", $time, want.ranged,
                     out_tdata[63:32]);
            errors++;
          end
          if (out_tuser[0] !== want.empty) begin
            $display("%0t: empty_range expected %b, actual %b", $time, want.empty,
                     out_tuser[0]);
            errors++;
          end
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    out_tready = 1'b0;

    // Directed: span extremes, empty spans, reversed bounds, reseed wrap and odd states
    add_item(OP_DRAW,   32'h0000_0000, 32'd0,         32'd100);
    add_item(OP_DRAW,   32'hFFFF_FFFF, 32'd5,         32'd5);
    add_item(OP_DRAW,   32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    add_item(OP_DRAW,   32'h0000_0000, 32'd100,       -32'sd100);
    add_item(OP_DRAW,   32'h0000_0000, 32'd7,         32'd8);
    add_item(OP_DRAW,   32'h0000_0000, 32'h8000_0000, 32'h8000_0000);
    add_item(OP_DRAW,   32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    add_item(OP_DRAW,   32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
    add_item(OP_RESEED, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    add_item(OP_DRAW,   32'h0000_0000, 32'd0,         32'd1000);
    add_item(OP_RESEED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_item(OP_DRAW,   32'h0000_0000, 32'd0,         32'd1000);
    add_item(OP_RESEED, 32'hFFFF_FFFE, 32'h0000_0000, 32'h0000_0000);
    add_item(OP_DRAW,   32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    add_item(OP_DRAW,   32'h0000_0000, 32'd0,         32'hFFFF_FFFF);
    add_item(OP_RESEED, 32'h7FFF_FFFE, 32'h0000_0000, 32'h0000_0000);
    add_item(OP_DRAW,   32'h0000_0000, 32'd0,         32'd3);
    add_item(OP_RESEED, 32'h7FFF_FFFD, 32'h0000_0000, 32'h0000_0000);
    add_item(OP_DRAW,   32'h0000_0000, -32'sd50,      32'sd50);
    add_item(OP_RESEED, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_item(OP_DRAW,   32'hFFFF_FFFF, 32'd0,         32'h8000_0000);
    add_item(OP_RESEED, 32'h1234_5678, 32'h0000_0000, 32'h0000_0000);
    add_item(OP_DRAW,   32'h0000_0000, 32'h8000_0000, 32'h8000_0001);
    repeat (RANDOM_ITEMS) add_random_item();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Drain: all items taken, all results in, then a tail for stray outputs
    while (request_queue.size() != 0 || in_tvalid) @(posedge clk);
    while (awaited_outputs.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Timeout
  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: park_miller_random_generator_unit.f
+incdir+rtl
rtl/pmrg_pkg.sv
rtl/pmrg_ctrl.sv
rtl/pmrg_dp.sv
rtl/park_miller_random_generator_unit.sv
bench/tb_top.sv
